[rtl/core/tts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the tach throttle command selector.
// ----------------------------------------------------------------------------
package tts_pkg;

    // Transaction payloads
    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  capture_value;
        logic [11:0] throttle;
        logic        brake;
        logic        reverse_switch;
    } in_t;

    typedef struct packed {
        logic        command_valid;
        logic [2:0]  command_code;
        logic [19:0] rpm;
        logic [18:0] speed_hundredths;
        logic [3:0]  led_pattern;
    } out_t;

    // Configuration registers
    typedef struct packed {
        logic [19:0] rpm_numerator;
        logic [15:0] overflow_timeout;
        logic [11:0] level_one;
        logic [11:0] level_two;
        logic [11:0] level_three;
        logic [11:0] level_four;
    } cfg_t;

    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_RPM_NUMERATOR = 3'd0,
        REG_OVF_TIMEOUT   = 3'd1,
        REG_LEVEL_ONE     = 3'd2,
        REG_LEVEL_TWO     = 3'd3,
        REG_LEVEL_THREE   = 3'd4,
        REG_LEVEL_FOUR    = 3'd5
    } reg_idx_t;

    localparam logic [19:0] RST_RPM_NUMERATOR = 20'd937500;
    localparam logic [15:0] RST_OVF_TIMEOUT   = 16'd200;
    localparam logic [11:0] RST_LEVEL_ONE     = 12'd1100;
    localparam logic [11:0] RST_LEVEL_TWO     = 12'd1700;
    localparam logic [11:0] RST_LEVEL_THREE   = 12'd2300;
    localparam logic [11:0] RST_LEVEL_FOUR    = 12'd2800;

    // Request kinds
    localparam logic [1:0] REQ_EDGE    = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_CONTROL = 2'd2;

    // Command codes
    localparam logic [2:0] CMD_STOP    = 3'd0;
    localparam logic [2:0] CMD_STEP1   = 3'd1;
    localparam logic [2:0] CMD_STEP2   = 3'd2;
    localparam logic [2:0] CMD_STEP4   = 3'd4;
    localparam logic [2:0] CMD_STEP5   = 3'd5;
    localparam logic [2:0] CMD_BRAKE   = 3'd6;
    localparam logic [2:0] CMD_REVERSE = 3'd7;

    // Capture phases
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    // Lamp patterns
    localparam logic [3:0] LAMP_TIMEOUT = 4'b0001;
    localparam logic [3:0] LAMP_BAND_A  = 4'b0010;
    localparam logic [3:0] LAMP_BAND_B  = 4'b0100;
    localparam logic [3:0] LAMP_BAND_MASK = 4'b1110;

    // Speed bands (rpm)
    localparam logic [19:0] RPM_BAND_MIN   = 20'd5;
    localparam logic [19:0] RPM_BAND_ONE   = 20'd605;
    localparam logic [19:0] RPM_BAND_TWO   = 20'd760;
    localparam logic [19:0] RPM_BAND_THREE = 20'd1280;

    localparam int TIMER_PERIOD = 256;
    localparam int PERIOD_W     = 24;
    localparam logic [15:0] OVF_MAX = 16'hFFFF;

    // speed = rpm * SPEED_MUL / SPEED_DIV
    localparam logic [8:0]  SPEED_MUL = 9'd297;
    localparam logic [23:0] SPEED_DIV = 24'd625;

    // Same floor as (rpm * rpm_max_err) < 2^SPD_SHIFT holds for any 20-bit rpm:
    // speed = (rpm * SPEED_RECIP) >> SPD_SHIFT, SPEED_RECIP = ceil(297 * 2^30 / 625)
    localparam int          SPD_SHIFT   = 30;
    localparam int          SPD_PROD_W  = 49;
    localparam logic [28:0] SPEED_RECIP = 29'd510242115;

    // Divider: numerator / period, quotient in the dividend register
    localparam int DVD_W = 20;
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] RPM_STEPS = CNT_W'(DVD_W);

    typedef struct packed {
        logic                start;
        logic [DVD_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
        logic [CNT_W-1:0]    steps;
    } div_req_t;

endpackage

[rtl/core/tts_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tts_divider
    import tts_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] dsr_reg, dsr_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        dvd_next = dvd_reg;
        if (req.start) begin
            cnt_next = req.steps;
            rem_next = '0;
            dsr_next = req.divisor;
            dvd_next = req.dividend;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = dvd_reg;

endmodule

[rtl/core/tts_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_ctrl
// Event sequencer: capture state, speed measurement and command selection.
// ----------------------------------------------------------------------------
module tts_ctrl
    import tts_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  in_t              in_data,
    output logic             in_ready,
    input  logic             out_free,
    output logic             res_load,
    output out_t             res_data,
    output div_req_t         div_req,
    input  logic             div_busy,
    input  logic [DVD_W-1:0] div_quotient
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RPM_GO,
        ST_RPM_WAIT,
        ST_MUL,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [7:0]          first_reg, first_next;
    logic [15:0]         ovf_reg, ovf_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [11:0]         band_reg, band_next;
    logic [19:0]         rpm_reg, rpm_next;
    logic [18:0]         speed_reg, speed_next;
    logic [3:0]          lamp_reg, lamp_next;
    logic                cvalid_reg, cvalid_next;
    logic [2:0]          code_reg, code_next;
    logic [11:0]         thr_reg, thr_next;
    logic                brk_reg, brk_next;
    logic                rev_reg, rev_next;
    logic                stopped_reg, stopped_next;
    logic [SPD_PROD_W-1:0] spd_prod;

    // speed in hundredths by reciprocal multiply, exact floor for 20-bit rpm
    assign spd_prod = SPD_PROD_W'(rpm_reg) * SPD_PROD_W'(SPEED_RECIP);

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        first_next   = first_reg;
        ovf_next     = ovf_reg;
        period_next  = period_reg;
        band_next    = band_reg;
        rpm_next     = rpm_reg;
        speed_next   = speed_reg;
        lamp_next    = lamp_reg;
        cvalid_next  = cvalid_reg;
        code_next    = code_reg;
        thr_next     = thr_reg;
        brk_next     = brk_reg;
        rev_next     = rev_reg;
        stopped_next = stopped_reg;
        res_load     = 1'b0;
        div_req      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cvalid_next = 1'b0;
                    code_next   = CMD_STOP;
                    state_next  = ST_EMIT;
                    case (in_data.req_type)
                        REQ_EDGE: begin
                            case (phase_reg)
                                PH_SECOND: phase_next = PH_THIRD;
                                PH_THIRD: begin
                                    period_next = PERIOD_W'(in_data.capture_value)
                                        + PERIOD_W'(32'(ovf_reg) * TIMER_PERIOD)
                                        - PERIOD_W'(first_reg);
                                    phase_next = PH_FIRST;
                                end
                                default: begin
                                    first_next = in_data.capture_value;
                                    ovf_next   = '0;
                                    phase_next = PH_SECOND;
                                end
                            endcase
                        end
                        REQ_TICK: begin
                            if (ovf_reg != OVF_MAX) begin
                                ovf_next = ovf_reg + 1'b1;
                            end
                        end
                        REQ_CONTROL: begin
                            thr_next     = in_data.throttle;
                            brk_next     = in_data.brake;
                            rev_next     = in_data.reverse_switch;
                            stopped_next = (rpm_reg == '0);
                            state_next   = ST_RPM_GO;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RPM_GO: begin
                if (period_reg == '0) begin
                    rpm_next   = '0;
                    state_next = ST_MUL;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = cfg.rpm_numerator;
                    div_req.divisor  = period_reg;
                    div_req.steps    = RPM_STEPS;
                    state_next       = ST_RPM_WAIT;
                end
            end
            ST_RPM_WAIT: begin
                if (!div_busy) begin
                    rpm_next   = div_quotient[19:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                speed_next = spd_prod[SPD_SHIFT +: 19];
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_EMIT;
                if (brk_reg) begin
                    cvalid_next = 1'b1;
                    code_next   = CMD_BRAKE;
                end else if (stopped_reg && rev_reg) begin
                    cvalid_next = 1'b1;
                    code_next   = (thr_reg > cfg.level_one) ? CMD_REVERSE : CMD_STOP;
                end else begin
                    // speed band; exact band edges keep the previous band
                    if (rpm_reg < RPM_BAND_ONE && rpm_reg > RPM_BAND_MIN) begin
                        band_next = cfg.level_one;
                        lamp_next = LAMP_BAND_A;
                    end else if (rpm_reg > RPM_BAND_ONE && rpm_reg < RPM_BAND_TWO) begin
                        band_next = cfg.level_two;
                        lamp_next = LAMP_BAND_B;
                    end else if (rpm_reg > RPM_BAND_TWO && rpm_reg < RPM_BAND_THREE) begin
                        band_next = cfg.level_three;
                        lamp_next = LAMP_BAND_A;
                    end else if (rpm_reg > RPM_BAND_THREE) begin
                        band_next = cfg.level_four;
                        lamp_next = LAMP_BAND_A;
                    end
                    // stall timeout
                    if (ovf_reg > cfg.overflow_timeout) begin
                        period_next = '0;
                        band_next   = cfg.level_one;
                        lamp_next   = LAMP_TIMEOUT;
                        phase_next  = PH_FIRST;
                    end else begin
                        lamp_next = lamp_next & LAMP_BAND_MASK;
                    end
                    cvalid_next = 1'b1;
                    if (band_next > thr_reg) begin
                        code_next = CMD_STOP;
                    end else if (thr_reg > cfg.level_one && thr_reg < cfg.level_two) begin
                        code_next = CMD_STEP1;
                    end else if (thr_reg >= cfg.level_two && thr_reg < cfg.level_three) begin
                        code_next = CMD_STEP2;
                    end else if (thr_reg >= cfg.level_three && thr_reg < cfg.level_four) begin
                        code_next = CMD_STEP4;
                    end else if (thr_reg >= cfg.level_four) begin
                        code_next = CMD_STEP5;
                    end else begin
                        cvalid_next = 1'b0;
                        code_next   = CMD_STOP;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_FIRST;
            first_reg  <= '0;
            ovf_reg    <= '0;
            period_reg <= '0;
            band_reg   <= RST_LEVEL_ONE;
            rpm_reg    <= '0;
            speed_reg  <= '0;
            lamp_reg   <= '0;
            cvalid_reg <= 1'b0;
            code_reg   <= CMD_STOP;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            ovf_reg    <= ovf_next;
            period_reg <= period_next;
            band_reg   <= band_next;
            rpm_reg    <= rpm_next;
            speed_reg  <= speed_next;
            lamp_reg   <= lamp_next;
            cvalid_reg <= cvalid_next;
            code_reg   <= code_next;
        end
        thr_reg     <= thr_next;
        brk_reg     <= brk_next;
        rev_reg     <= rev_next;
        stopped_reg <= stopped_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        res_data.command_valid    = cvalid_reg;
        res_data.command_code     = code_reg;
        res_data.rpm              = rpm_reg;
        res_data.speed_hundredths = speed_reg;
        res_data.led_pattern      = lamp_reg;
    end

endmodule

[rtl/core/tach_throttle_command_selector_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_throttle_command_selector_top
// Tachometer capture, rpm/speed measurement and throttle command selection.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready) takes one event transaction: capture edge,
//   timer overflow tick or control update. m_* channel (valid/ready) returns
//   exactly one result transaction per event with the command (if any), rpm,
//   speed in hundredths and the lamp pattern.
//   An edge or tick event goes from idle straight to the emit step, which
//   loads the result register; the next event is taken after that.
//   A control update divides numerator by period on the radix-2
//   divider (20 steps), then one reciprocal multiply gives speed and a
//   decide step picks the command before the emit step. With a zero
//   period the divide is skipped.
//   s_ready is high only while the sequencer is idle; one event at a time.
//   The result sits in an output register, so the next event is taken
//   while a result waits; a stalled receiver holds the sequencer in its
//   final step until the register frees up.
//   Reset (aresetn, synchronous) loads register defaults and clears the
//   capture state; the APB port (pready tied high) may be written whenever
//   no event is in flight.
// ----------------------------------------------------------------------------
module tach_throttle_command_selector_top
    import tts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // event input
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    // result output
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t             cfg_reg, cfg_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;
    logic             out_free;
    logic             res_load;
    out_t             res_data;
    div_req_t         div_req;
    logic             div_busy;
    logic [DVD_W-1:0] div_quotient;
    logic             apb_wr;
    reg_idx_t         reg_idx;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb begin
        cfg_next = cfg_reg;
        if (apb_wr) begin
            case (reg_idx)
                REG_RPM_NUMERATOR: cfg_next.rpm_numerator    = pwdata[19:0];
                REG_OVF_TIMEOUT:   cfg_next.overflow_timeout = pwdata[15:0];
                REG_LEVEL_ONE:     cfg_next.level_one        = pwdata[11:0];
                REG_LEVEL_TWO:     cfg_next.level_two        = pwdata[11:0];
                REG_LEVEL_THREE:   cfg_next.level_three      = pwdata[11:0];
                REG_LEVEL_FOUR:    cfg_next.level_four       = pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RPM_NUMERATOR: prdata = 32'(cfg_reg.rpm_numerator);
            REG_OVF_TIMEOUT:   prdata = 32'(cfg_reg.overflow_timeout);
            REG_LEVEL_ONE:     prdata = 32'(cfg_reg.level_one);
            REG_LEVEL_TWO:     prdata = 32'(cfg_reg.level_two);
            REG_LEVEL_THREE:   prdata = 32'(cfg_reg.level_three);
            REG_LEVEL_FOUR:    prdata = 32'(cfg_reg.level_four);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rpm_numerator    <= RST_RPM_NUMERATOR;
            cfg_reg.overflow_timeout <= RST_OVF_TIMEOUT;
            cfg_reg.level_one        <= RST_LEVEL_ONE;
            cfg_reg.level_two        <= RST_LEVEL_TWO;
            cfg_reg.level_three      <= RST_LEVEL_THREE;
            cfg_reg.level_four       <= RST_LEVEL_FOUR;
            m_valid_reg              <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Sequencer and divider
    // ------------------------------------------------------------------
    tts_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_valid),
        .in_data      (s_data),
        .in_ready     (s_ready),
        .out_free     (out_free),
        .res_load     (res_load),
        .res_data     (res_data),
        .div_req      (div_req),
        .div_busy     (div_busy),
        .div_quotient (div_quotient)
    );

    tts_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

`ifndef ASSERT_OFF
    // no new event while a division is running
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> !s_ready)
        else $error("event accepted during division");

    // one event at a time: ready drops right after an accept
    a_accept_drops_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready held after accept");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("pending result overwritten");

    // no command means code stop
    a_code_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.command_valid || m_data.command_code == CMD_STOP))
        else $error("command code without command");
`endif

endmodule

[tb/tach_throttle_command_selector_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_throttle_command_selector_top_tb
// Self-checking bench for the tach throttle command selector.
// A cycle-free predictor tracks capture phase, overflow count, period, band
// and lamps, and predicts one report per event. Directed checks cover each
// command path, exact band edges and the timeout. A long tick run gives a
// period wider than 16 bits. Random traffic then runs under several register sets.
// ----------------------------------------------------------------------------
module tach_throttle_command_selector_top_tb;
    import tts_pkg::*;

    // req_type 3 is not decoded by the block; it reports like a tick
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_t               s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_t              m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    tach_throttle_command_selector_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register shadow plus the block's measurement state.
    // ------------------------------------------------------------------------
    cfg_t        cfg_model;
    logic [1:0]  cap_phase;
    logic [7:0]  first_stamp;
    logic [15:0] ovf_ticks;
    logic [23:0] period_cnt;
    logic [11:0] band_lim;
    logic [19:0] rpm_last;
    logic [18:0] speed_last;
    logic [3:0]  lamps;

    // Reports predicted for accepted transactions, oldest first
    out_t pending_reports[$];

    int  mismatch_cnt  = 0;
    int  accepted_cnt  = 0;
    int  control_cnt   = 0;
    int  checked_cnt   = 0;
    int  reg_write_cnt = 0;
    int  cmd_seen[8];
    bit  src_gaps = 1'b1;
    bit  snk_gaps = 1'b1;

    task automatic reset_model();
        cfg_model   = '{RST_RPM_NUMERATOR, RST_OVF_TIMEOUT, RST_LEVEL_ONE,
                        RST_LEVEL_TWO, RST_LEVEL_THREE, RST_LEVEL_FOUR};
        cap_phase   = PH_FIRST;
        first_stamp = '0;
        ovf_ticks   = '0;
        period_cnt  = '0;
        band_lim    = RST_LEVEL_ONE;
        rpm_last    = '0;
        speed_last  = '0;
        lamps       = '0;
    endtask

    // Advances the predictor by one event and returns the report it causes.
    function automatic out_t compute_report(input in_t ev);
        out_t        rep;
        logic        was_stopped;
        logic [31:0] span;
        logic [31:0] prod;
        rep = '0;
        case (ev.req_type)
            REQ_EDGE: begin
                if (cap_phase == PH_SECOND) begin
                    cap_phase = PH_THIRD;
                end else if (cap_phase == PH_THIRD) begin
                    // period wraps at 24 bits, including a "negative" span
                    span = 32'(ev.capture_value) + 32'(ovf_ticks) * 32'(TIMER_PERIOD)
                           - 32'(first_stamp);
                    period_cnt = span[23:0];
                    cap_phase  = PH_FIRST;
                end else begin
                    first_stamp = ev.capture_value;
                    ovf_ticks   = '0;
                    cap_phase   = PH_SECOND;
                end
            end
            REQ_TICK: begin
                if (ovf_ticks != OVF_MAX) ovf_ticks = ovf_ticks + 16'd1;
            end
            REQ_CONTROL: begin
                was_stopped = (rpm_last == '0);
                if (period_cnt == '0) begin
                    rpm_last = '0;
                end else begin
                    rpm_last = 20'(32'(cfg_model.rpm_numerator) / 32'(period_cnt));
                end
                prod       = 32'(rpm_last) * 32'(SPEED_MUL);
                speed_last = 19'(prod / 32'(SPEED_DIV));
                if (ev.brake) begin
                    rep.command_valid = 1'b1;
                    rep.command_code  = CMD_BRAKE;
                end else if (was_stopped && ev.reverse_switch) begin
                    rep.command_valid = 1'b1;
                    rep.command_code  = (ev.throttle > cfg_model.level_one) ?
                                        CMD_REVERSE : CMD_STOP;
                end else begin
                    // exact band edges and very low rpm keep the old band
                    if (rpm_last < RPM_BAND_ONE && rpm_last > RPM_BAND_MIN) begin
                        band_lim = cfg_model.level_one;
                        lamps    = LAMP_BAND_A;
                    end else if (rpm_last > RPM_BAND_ONE && rpm_last < RPM_BAND_TWO) begin
                        band_lim = cfg_model.level_two;
                        lamps    = LAMP_BAND_B;
                    end else if (rpm_last > RPM_BAND_TWO && rpm_last < RPM_BAND_THREE) begin
                        band_lim = cfg_model.level_three;
                        lamps    = LAMP_BAND_A;
                    end else if (rpm_last > RPM_BAND_THREE) begin
                        band_lim = cfg_model.level_four;
                        lamps    = LAMP_BAND_A;
                    end
                    if (ovf_ticks > cfg_model.overflow_timeout) begin
                        period_cnt = '0;
                        band_lim   = cfg_model.level_one;
                        lamps      = LAMP_TIMEOUT;
                        cap_phase  = PH_FIRST;
                    end else begin
                        lamps = lamps & LAMP_BAND_MASK;
                    end
                    rep.command_valid = 1'b1;
                    if (band_lim > ev.throttle) begin
                        rep.command_code = CMD_STOP;
                    end else if (ev.throttle > cfg_model.level_one &&
                                 ev.throttle < cfg_model.level_two) begin
                        rep.command_code = CMD_STEP1;
                    end else if (ev.throttle >= cfg_model.level_two &&
                                 ev.throttle < cfg_model.level_three) begin
                        rep.command_code = CMD_STEP2;
                    end else if (ev.throttle >= cfg_model.level_three &&
                                 ev.throttle < cfg_model.level_four) begin
                        rep.command_code = CMD_STEP4;
                    end else if (ev.throttle >= cfg_model.level_four) begin
                        rep.command_code = CMD_STEP5;
                    end else begin
                        rep.command_valid = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        rep.rpm              = rpm_last;
        rep.speed_hundredths = speed_last;
        rep.led_pattern      = lamps;
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure at the falling edge, checks at the
    // rising edge against the oldest pending report.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= !(snk_gaps && $urandom_range(0, 99) < 25);
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                mismatch_cnt++;
                $display("%0t ns: unexpected result transaction, expected none, actual %h",
                         $time, m_data);
            end else begin
                want = pending_reports.pop_front();
                checked_cnt++;
                if (m_data.command_valid === 1'b1) cmd_seen[m_data.command_code]++;
                check_field("command_valid", 32'(want.command_valid),
                            32'(m_data.command_valid));
                check_field("command_code", 32'(want.command_code), 32'(m_data.command_code));
                check_field("rpm", 32'(want.rpm), 32'(m_data.rpm));
                check_field("speed_hundredths", 32'(want.speed_hundredths),
                            32'(m_data.speed_hundredths));
                check_field("led_pattern", 32'(want.led_pattern), 32'(m_data.led_pattern));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event side. Entered and left at a falling edge; valid is only lowered
    // when a gap is taken, so it is never dropped and raised in one step.
    // ------------------------------------------------------------------------
    task automatic send_event(input in_t ev);
        while (src_gaps && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        pending_reports.push_back(compute_report(ev));
        accepted_cnt++;
        if (ev.req_type == REQ_CONTROL) control_cnt++;
        @(negedge aclk);
    endtask

    function automatic in_t random_item();
        in_t ev;
        ev.req_type       = 2'($urandom_range(0, 3));
        ev.capture_value  = 8'($urandom_range(0, 255));
        ev.throttle       = 12'($urandom_range(0, 4095));
        ev.brake          = 1'($urandom_range(0, 1));
        ev.reverse_switch = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    task automatic send_edge(input logic [7:0] stamp);
        in_t ev;
        ev = random_item();
        ev.req_type      = REQ_EDGE;
        ev.capture_value = stamp;
        send_event(ev);
    endtask

    task automatic send_tick();
        in_t ev;
        ev = random_item();
        ev.req_type = REQ_TICK;
        send_event(ev);
    endtask

    task automatic send_ctrl(input logic [11:0] thr, input logic brk, input logic rev);
        in_t ev;
        ev = random_item();
        ev.req_type       = REQ_CONTROL;
        ev.throttle       = thr;
        ev.brake          = brk;
        ev.reverse_switch = rev;
        send_event(ev);
    endtask

    // Hold the sender until every pending report has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // APB access. pready is tied high, so each access is setup + access.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] reg_mask(input reg_idx_t idx);
        case (idx)
            REG_RPM_NUMERATOR: return 32'hF_FFFF;
            REG_OVF_TIMEOUT:   return 32'hFFFF;
            default:           return 32'hFFF;
        endcase
    endfunction

    task automatic reg_read(input reg_idx_t idx, input logic [31:0] want);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== (want & reg_mask(idx))) begin
            mismatch_cnt++;
            $display("%0t ns: register %s read expected %0d, actual %0d", $time,
                     idx.name(), want & reg_mask(idx), prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RPM_NUMERATOR: cfg_model.rpm_numerator    = val[19:0];
            REG_OVF_TIMEOUT:   cfg_model.overflow_timeout = val[15:0];
            REG_LEVEL_ONE:     cfg_model.level_one        = val[11:0];
            REG_LEVEL_TWO:     cfg_model.level_two        = val[11:0];
            REG_LEVEL_THREE:   cfg_model.level_three      = val[11:0];
            default:           cfg_model.level_four       = val[11:0];
        endcase
        reg_write_cnt++;
        @(negedge aclk);
        reg_read(idx, val);
    endtask

    task automatic load_config(input cfg_t c);
        reg_write(REG_RPM_NUMERATOR, 32'(c.rpm_numerator));
        reg_write(REG_OVF_TIMEOUT, 32'(c.overflow_timeout));
        reg_write(REG_LEVEL_ONE, 32'(c.level_one));
        reg_write(REG_LEVEL_TWO, 32'(c.level_two));
        reg_write(REG_LEVEL_THREE, 32'(c.level_three));
        reg_write(REG_LEVEL_FOUR, 32'(c.level_four));
    endtask

    function automatic cfg_t random_config(input bit ordered);
        cfg_t c;
        c.rpm_numerator    = 20'($urandom_range(1, 20'hF_FFFF));
        c.overflow_timeout = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 40))
                                                         : 16'($urandom_range(1, 65535));
        if (ordered) begin
            c.level_one   = 12'($urandom_range(0, 1500));
            c.level_two   = c.level_one + 12'($urandom_range(0, 900));
            c.level_three = c.level_two + 12'($urandom_range(0, 900));
            c.level_four  = c.level_three + 12'($urandom_range(0, 795));
        end else begin
            c.level_one   = 12'($urandom_range(0, 4095));
            c.level_two   = 12'($urandom_range(0, 4095));
            c.level_three = 12'($urandom_range(0, 4095));
            c.level_four  = 12'($urandom_range(0, 4095));
        end
        return c;
    endfunction

    // Throttle near a level (one below, on, one above) half the time
    function automatic logic [11:0] pick_throttle();
        logic [11:0] nudge;
        nudge = 12'($urandom_range(0, 2)) - 12'd1;
        case ($urandom_range(0, 7))
            0: return cfg_model.level_one + nudge;
            1: return cfg_model.level_two + nudge;
            2: return cfg_model.level_three + nudge;
            3: return cfg_model.level_four + nudge;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every register must read back its reset value.
    task automatic test_register_defaults();
        reg_read(REG_RPM_NUMERATOR, 32'(RST_RPM_NUMERATOR));
        reg_read(REG_OVF_TIMEOUT, 32'(RST_OVF_TIMEOUT));
        reg_read(REG_LEVEL_ONE, 32'(RST_LEVEL_ONE));
        reg_read(REG_LEVEL_TWO, 32'(RST_LEVEL_TWO));
        reg_read(REG_LEVEL_THREE, 32'(RST_LEVEL_THREE));
        reg_read(REG_LEVEL_FOUR, 32'(RST_LEVEL_FOUR));
    endtask

    // Walks each command path from a known state.
    task automatic test_command_paths();
        // zero period after reset: stopped, so reverse decides
        send_ctrl(12'hFFF, 1'b0, 1'b1);          // reverse above level one
        send_ctrl(12'h000, 1'b0, 1'b1);          // reverse at rest -> stop
        send_ctrl(12'hFFF, 1'b1, 1'b1);          // brake wins over reverse
        send_event('{REQ_UNUSED, 8'hFF, 12'hFFF, 1'b1, 1'b1});
        // period 99 + 256 - 255 = 100 ticks -> 9375 rpm, top band
        send_edge(8'hFF);
        send_tick();
        send_edge(8'h00);
        send_edge(8'd99);
        send_ctrl(12'hFFF, 1'b0, 1'b0);
        // exact band edges and very low rpm leave band and lamps alone
        reg_write(REG_RPM_NUMERATOR, 32'd60500);
        send_ctrl(12'd2000, 1'b0, 1'b0);
        reg_write(REG_RPM_NUMERATOR, 32'd76000);
        send_ctrl(12'd2000, 1'b0, 1'b0);
        reg_write(REG_RPM_NUMERATOR, 32'd128000);
        send_ctrl(12'd2000, 1'b0, 1'b0);
        reg_write(REG_RPM_NUMERATOR, 32'd500);
        send_ctrl(12'd2000, 1'b0, 1'b0);
        reg_write(REG_RPM_NUMERATOR, 32'd70000);  // 700 rpm, middle band
        send_ctrl(12'd1800, 1'b0, 1'b0);
        // 600 rpm, low band: walk the throttle steps (reverse ignored, moving)
        reg_write(REG_RPM_NUMERATOR, 32'd60000);
        send_ctrl(12'd1500, 1'b0, 1'b1);
        send_ctrl(12'd2500, 1'b0, 1'b0);
        send_ctrl(12'd3000, 1'b0, 1'b0);
        send_ctrl(12'd1100, 1'b0, 1'b0);          // on level one: no command
        send_ctrl(12'd1099, 1'b0, 1'b0);
        // overflow timeout clears the period and lights the timeout lamp
        reg_write(REG_OVF_TIMEOUT, 32'd1);
        send_tick();
        send_tick();
        send_ctrl(12'd2000, 1'b0, 1'b0);
        send_ctrl(12'd2000, 1'b0, 1'b0);
        send_ctrl(12'd2000, 1'b0, 1'b1);
        // zero numerator and unordered levels
        reg_write(REG_RPM_NUMERATOR, 32'd0);
        reg_write(REG_OVF_TIMEOUT, 32'(RST_OVF_TIMEOUT));
        reg_write(REG_LEVEL_ONE, 32'd4095);
        reg_write(REG_LEVEL_TWO, 32'd3000);
        reg_write(REG_LEVEL_THREE, 32'd1000);
        reg_write(REG_LEVEL_FOUR, 32'd0);
        send_edge(8'd10);
        send_edge(8'd20);
        send_edge(8'd60);
        send_ctrl(12'd2000, 1'b0, 1'b0);
    endtask

    // Runs the overflow count past 255 so the measured period needs more
    // than 16 bits, then measures across it.
    task automatic test_long_overflow_run();
        load_config('{RST_RPM_NUMERATOR, 16'hFFFF, RST_LEVEL_ONE, RST_LEVEL_TWO,
                      RST_LEVEL_THREE, RST_LEVEL_FOUR});
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        send_edge(8'd7);
        repeat (260) send_tick();
        send_edge(8'd128);
        send_edge(8'd250);
        send_ctrl(12'd3000, 1'b0, 1'b0);
        send_tick();
        send_ctrl(12'd500, 1'b0, 1'b0);
        wait_drained();
    endtask

    // Mostly well-formed measure-then-control bursts with random content,
    // the rest random transactions that break sequences.
    task automatic run_traffic_phase(input int quota, input bit gaps);
        int   sent;
        int   r;
        int   k1;
        int   k2;
        int   n;
        logic [7:0] stamp;
        logic [7:0] last_cap;
        in_t  ev;
        src_gaps = gaps;
        snk_gaps = gaps;
        sent = 0;
        while (sent < quota) begin
            r = $urandom_range(0, 99);
            if (r < 2) wait_drained();
            if (r < 72) begin
                stamp    = 8'($urandom_range(0, 255));
                last_cap = 8'($urandom_range(0, 255));
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    k1 = 0;                     // zero period
                    k2 = 0;
                    last_cap = stamp;
                end else if (r < 82) begin
                    k1 = $urandom_range(0, 4);
                    k2 = $urandom_range(0, 3);
                end else if (r < 96) begin
                    k1 = $urandom_range(5, 20);
                    k2 = $urandom_range(0, 10);
                end else begin
                    k1 = $urandom_range(150, 260);
                    k2 = 0;
                end
                send_edge(stamp);
                repeat (k1) send_tick();
                send_edge(8'($urandom_range(0, 255)));
                repeat (k2) send_tick();
                send_edge(last_cap);
                n = $urandom_range(1, 4);
                repeat (n) send_ctrl(pick_throttle(), 1'($urandom_range(0, 99) < 15),
                                     1'($urandom_range(0, 99) < 30));
                sent += 3 + k1 + k2 + n;
            end else begin
                ev = random_item();
                send_event(ev);
                if (ev.req_type != REQ_UNUSED) sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        load_config('{RST_RPM_NUMERATOR, RST_OVF_TIMEOUT, RST_LEVEL_ONE, RST_LEVEL_TWO,
                      RST_LEVEL_THREE, RST_LEVEL_FOUR});
        run_traffic_phase(350, 1'b1);
        load_config('{20'hF_FFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
        run_traffic_phase(150, 1'b1);
        load_config('{20'd1, 16'd1, 12'd0, 12'd0, 12'd0, 12'd0});
        run_traffic_phase(150, 1'b1);
        // long stretch with no idling on either side
        load_config(random_config(1'b1));
        run_traffic_phase(350, 1'b0);
        load_config(random_config(1'b0));
        run_traffic_phase(300, 1'b1);
        load_config(random_config(1'b1));
        run_traffic_phase(350, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, run the tests, let the pipe empty, report.
    // ------------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_register_defaults();
        test_command_paths();
        test_long_overflow_run();
        test_random_traffic();

        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("Run covered %0d transactions (%0d control updates), %0d results checked,",
                 accepted_cnt, control_cnt, checked_cnt);
        $display("%0d register writes; commands seen 0:%0d 1:%0d 2:%0d 4:%0d 5:%0d 6:%0d 7:%0d",
                 reg_write_cnt, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[4],
                 cmd_seen[5], cmd_seen[6], cmd_seen[7]);
        if (mismatch_cnt == 0 && pending_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial begin
        #25_000_000;
        $display("Timeout with %0d results still pending", pending_reports.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
